### rtl/wfmc_pkg.sv
// ----------------------------------------------------------------------------
// wfmc_pkg: wall follow mode controller shared definitions
// payload structs, register set, mode and drive command codes
// ----------------------------------------------------------------------------
package wfmc_pkg;

    localparam int unsigned DIST_W  = 10;
    localparam int unsigned CMD_W   = 4;
    localparam int unsigned MODE_W  = 3;
    localparam int unsigned CFG_IDX_W = 3;

    // mode codes
    localparam logic [MODE_W-1:0] M_START = 3'd0;
    localparam logic [MODE_W-1:0] M_ADJL  = 3'd1;
    localparam logic [MODE_W-1:0] M_ADJR  = 3'd2;
    localparam logic [MODE_W-1:0] M_FREEL = 3'd3;
    localparam logic [MODE_W-1:0] M_FREER = 3'd4;
    localparam logic [MODE_W-1:0] M_SPIN  = 3'd5;

    // drive command codes
    localparam logic [CMD_W-1:0] C_HOLD  = 4'd0;
    localparam logic [CMD_W-1:0] C_FAST  = 4'd1;
    localparam logic [CMD_W-1:0] C_SLOW  = 4'd2;
    localparam logic [CMD_W-1:0] C_SPINR = 4'd3;
    localparam logic [CMD_W-1:0] C_SPINL = 4'd4;
    localparam logic [CMD_W-1:0] C_ADJL  = 4'd5;
    localparam logic [CMD_W-1:0] C_ADJR  = 4'd6;
    localparam logic [CMD_W-1:0] C_TURNL = 4'd7;
    localparam logic [CMD_W-1:0] C_TURNR = 4'd8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] R_FAR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] R_NEAR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] R_CLEAR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] R_BLOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] R_BHIGH = 3'd4;

    // register reset values
    localparam logic [DIST_W-1:0] FAR_RST   = 10'd60;
    localparam logic [DIST_W-1:0] NEAR_RST  = 10'd20;
    localparam logic [DIST_W-1:0] CLEAR_RST = 10'd25;
    localparam logic [DIST_W-1:0] BLOW_RST  = 10'd15;
    localparam logic [DIST_W-1:0] BHIGH_RST = 10'd18;

    typedef struct packed {
        logic [DIST_W-1:0] front_dist;
        logic [DIST_W-1:0] left_dist;
        logic [DIST_W-1:0] right_dist;
    } t_in;

    typedef struct packed {
        logic [CMD_W-1:0]  drive_cmd;
        logic              led_on;
        logic [MODE_W-1:0] mode_out;
    } t_out;

    typedef struct packed {
        logic [DIST_W-1:0] far_threshold;
        logic [DIST_W-1:0] near_threshold;
        logic [DIST_W-1:0] clear_threshold;
        logic [DIST_W-1:0] band_low;
        logic [DIST_W-1:0] band_high;
    } t_cfg;

endpackage

### rtl/wfmc_decide.sv
// ----------------------------------------------------------------------------
// wfmc_decide: drive command and mode transition network
// compares one sample against the thresholds given the current mode
// ----------------------------------------------------------------------------
module wfmc_decide (
    input  wfmc_pkg::t_cfg             i_cfg,
    input  logic [wfmc_pkg::MODE_W-1:0] i_mode,
    input  wfmc_pkg::t_in              i_sample,
    output wfmc_pkg::t_out             o_result
);
    import wfmc_pkg::*;

    logic [DIST_W-1:0] f, l, r;
    logic [CMD_W-1:0]  cmd;
    logic [MODE_W-1:0] nxt;
    logic              wallish;
    logic              f_clr, l_clr, r_clr;
    logic              l_near, r_near;

    function automatic logic [CMD_W-1:0] band_cmd(
        input logic [DIST_W-1:0] d,
        input logic [DIST_W-1:0] lo,
        input logic [DIST_W-1:0] hi,
        input logic [CMD_W-1:0]  below_cmd,
        input logic [CMD_W-1:0]  above_cmd
    );
        logic [CMD_W-1:0] c;
        if (d >= lo && d <= hi) begin
            c = C_SLOW;
        end else if (d < lo) begin
            c = below_cmd;
        end else if (d > hi) begin
            c = above_cmd;
        end else begin
            c = C_HOLD;
        end
        return c;
    endfunction

    assign f = i_sample.front_dist;
    assign l = i_sample.left_dist;
    assign r = i_sample.right_dist;

    assign f_clr  = f > i_cfg.clear_threshold;
    assign l_clr  = l > i_cfg.clear_threshold;
    assign r_clr  = r > i_cfg.clear_threshold;
    assign l_near = l <= i_cfg.near_threshold;
    assign r_near = r <= i_cfg.near_threshold;
    assign wallish = i_mode inside {M_ADJL, M_ADJR, M_FREEL, M_FREER};

    // drive command from the mode held before the sample
    always_comb begin
        cmd = C_HOLD;
        case (i_mode)
            M_START: begin
                if (f < r && f < l) begin
                    // front exactly at far leaves hold unless it is also at or below near
                    if (f > i_cfg.far_threshold) begin
                        cmd = C_FAST;
                    end else if (f < i_cfg.far_threshold && f > i_cfg.near_threshold) begin
                        cmd = C_SLOW;
                    end
                    if (f <= i_cfg.near_threshold) begin
                        cmd = C_SPINR;
                    end
                end else if (r < f && r < l) begin
                    cmd = C_SPINR;
                end else if (l < f && l < r) begin
                    cmd = C_SPINL;
                end else begin
                    cmd = C_FAST;
                end
            end
            M_ADJL: begin
                cmd = (f > i_cfg.near_threshold)
                    ? band_cmd(l, i_cfg.band_low, i_cfg.band_high, C_ADJR, C_ADJL)
                    : C_TURNR;
            end
            M_ADJR: begin
                cmd = (f > i_cfg.near_threshold)
                    ? band_cmd(r, i_cfg.band_low, i_cfg.band_high, C_ADJL, C_ADJR)
                    : C_TURNL;
            end
            M_FREEL: cmd = C_TURNL;
            M_FREER: cmd = C_TURNR;
            M_SPIN:  cmd = C_SPINR;
            default: cmd = C_HOLD;
        endcase
    end

    // ordered transition rules, first match wins
    always_comb begin
        if (i_mode == M_START && l_near) begin
            nxt = M_ADJL;
        end else if (i_mode == M_START && r_near) begin
            nxt = M_ADJR;
        end else if (i_mode == M_ADJL && f_clr && l_clr) begin
            nxt = M_FREEL;
        end else if (i_mode == M_ADJR && f_clr && r_clr) begin
            nxt = M_FREER;
        end else if (i_mode == M_FREEL && l_near) begin
            nxt = M_ADJL;
        end else if (i_mode == M_FREER && r_near) begin
            nxt = M_ADJR;
        end else if (wallish && !f_clr && !r_clr && !l_clr) begin
            nxt = M_SPIN;
        end else if (i_mode == M_ADJR && r > i_cfg.far_threshold) begin
            nxt = M_START;
        end else if (i_mode == M_ADJL && l > i_cfg.far_threshold) begin
            nxt = M_START;
        end else if (i_mode == M_SPIN && f_clr && l_near) begin
            nxt = M_ADJL;
        end else if (i_mode == M_SPIN && f_clr && r_near) begin
            nxt = M_ADJR;
        end else begin
            nxt = i_mode;
        end
    end

    assign o_result.drive_cmd = cmd;
    assign o_result.led_on    = (i_mode == M_START);
    assign o_result.mode_out  = nxt;

endmodule

### rtl/wall_follow_mode_controller_top.sv
// ----------------------------------------------------------------------------
// wall_follow_mode_controller_top: wall following mode controller
// one distance sample in, one drive command, led flag and new mode out
// ----------------------------------------------------------------------------
// each result passes the input register, then the result register
// throughput: 1 sample per cycle while results are taken; the mode register is
// written with each result, ready for the next sample; under backpressure the
// output register holds its result and a new request lands only in an empty input register
// reset (i_rst_n low, synchronous): mode to start, thresholds to defaults,
// both pipeline stages empty
module wall_follow_mode_controller_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // sample requests
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  wfmc_pkg::t_in                  i_in_data,
    // results
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output wfmc_pkg::t_out                 o_out_data,
    // register writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [wfmc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [wfmc_pkg::DIST_W-1:0]    i_cfg_data
);
    import wfmc_pkg::*;

    // threshold registers
    t_cfg r_cfg, n_cfg;

    // input stage
    logic r_in_valid;
    t_in  r_in;

    // result stage
    logic r_out_valid;
    t_out r_out;

    // mode state
    logic [MODE_W-1:0] r_mode;

    t_out w_result;
    logic w_advance;
    logic w_in_take;

    // result stage frees up when empty or drained this cycle
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;
    assign w_in_take  = i_in_valid && o_in_ready;

    // register writes are always taken
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                R_FAR:   n_cfg.far_threshold   = i_cfg_data;
                R_NEAR:  n_cfg.near_threshold  = i_cfg_data;
                R_CLEAR: n_cfg.clear_threshold = i_cfg_data;
                R_BLOW:  n_cfg.band_low        = i_cfg_data;
                R_BHIGH: n_cfg.band_high       = i_cfg_data;
                default: n_cfg = r_cfg;  // unmapped index, ignored
            endcase
        end
    end

    // decision network between the input and result registers
    wfmc_decide u_decide (
        .i_cfg    (r_cfg),
        .i_mode   (r_mode),
        .i_sample (r_in),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.far_threshold   <= FAR_RST;
            r_cfg.near_threshold  <= NEAR_RST;
            r_cfg.clear_threshold <= CLEAR_RST;
            r_cfg.band_low        <= BLOW_RST;
            r_cfg.band_high       <= BHIGH_RST;
            r_in_valid            <= 1'b0;
            r_out_valid           <= 1'b0;
            r_mode                <= M_START;
        end else begin
            r_cfg <= n_cfg;
            // input stage fills on accept, empties when it moves on
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            // result stage
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_mode      <= w_result.mode_out;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in <= i_in_data;
        end
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### dv/wall_follow_mode_controller_top_tb.sv
// ----------------------------------------------------------------------------
// wall_follow_mode_controller_top_tb: self-checking bench for the mode controller
// drives distance sample requests and register writes and predicts every result
// in lockstep with the mode register, checking drive command, led flag and mode
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module wall_follow_mode_controller_top_tb;
    import wfmc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned DRAIN_CYCLES = 4;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in_data = '0;

    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;

    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = R_FAR;
    logic [DIST_W-1:0]    i_cfg_data = '0;

    // predictor state: thresholds as last written and the mode after each request
    t_cfg              shadow_thr;
    logic [MODE_W-1:0] cur_mode;
    logic [5:0]        modes_seen;

    t_out        pending_results[$];
    t_out        want;
    int unsigned mismatches = 0;
    int unsigned results_checked = 0;
    int unsigned samples_sent = 0;
    int unsigned settings_applied = 0;
    int unsigned cycle_count = 0;
    int unsigned stall_left = 0;
    bit          no_idle = 1'b0;

    wall_follow_mode_controller_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // wall band tracking; an inverted band never fits, so each distance steers below or above
    function automatic logic [CMD_W-1:0] band_steer(logic [DIST_W-1:0] d,
                                                     logic [CMD_W-1:0] below_cmd,
                                                     logic [CMD_W-1:0] above_cmd);
        if (d >= shadow_thr.band_low && d <= shadow_thr.band_high) return C_SLOW;
        if (d < shadow_thr.band_low) return below_cmd;
        if (d > shadow_thr.band_high) return above_cmd;
        return C_HOLD;
    endfunction

    // command and led come from the mode held before the sample, then the
    // ordered transition rules pick the new mode
    function automatic t_out advance_mode(t_in s);
        t_out              r;
        logic [DIST_W-1:0] f;
        logic [DIST_W-1:0] l;
        logic [DIST_W-1:0] rt;
        logic [CMD_W-1:0]  c;
        logic [MODE_W-1:0] nx;
        logic              wallish;
        f  = s.front_dist;
        l  = s.left_dist;
        rt = s.right_dist;
        c  = C_HOLD;
        case (cur_mode)
            M_START: begin
                if (f < rt && f < l) begin
                    // front exactly at far gets no command, so hold
                    if (f > shadow_thr.far_threshold) c = C_FAST;
                    else if (f < shadow_thr.far_threshold && f > shadow_thr.near_threshold)
                        c = C_SLOW;
                    // near blocking wins over fast when near is at or above far
                    if (f <= shadow_thr.near_threshold) c = C_SPINR;
                end else if (rt < f && rt < l) begin
                    c = C_SPINR;
                end else if (l < f && l < rt) begin
                    c = C_SPINL;
                end else begin
                    c = C_FAST;
                end
            end
            M_ADJL: c = (f > shadow_thr.near_threshold) ? band_steer(l, C_ADJR, C_ADJL)
                                                        : C_TURNR;
            M_ADJR: c = (f > shadow_thr.near_threshold) ? band_steer(rt, C_ADJL, C_ADJR)
                                                        : C_TURNL;
            M_FREEL: c = C_TURNL;
            M_FREER: c = C_TURNR;
            M_SPIN:  c = C_SPINR;
            default: c = C_HOLD;
        endcase
        r.drive_cmd = c;
        r.led_on    = (cur_mode == M_START);

        wallish = (cur_mode == M_ADJL) || (cur_mode == M_ADJR) ||
                  (cur_mode == M_FREEL) || (cur_mode == M_FREER);
        nx = cur_mode;
        if (cur_mode == M_START && l <= shadow_thr.near_threshold) nx = M_ADJL;
        else if (cur_mode == M_START && rt <= shadow_thr.near_threshold) nx = M_ADJR;
        else if (cur_mode == M_ADJL && f > shadow_thr.clear_threshold &&
                 l > shadow_thr.clear_threshold) nx = M_FREEL;
        else if (cur_mode == M_ADJR && f > shadow_thr.clear_threshold &&
                 rt > shadow_thr.clear_threshold) nx = M_FREER;
        else if (cur_mode == M_FREEL && l <= shadow_thr.near_threshold) nx = M_ADJL;
        else if (cur_mode == M_FREER && rt <= shadow_thr.near_threshold) nx = M_ADJR;
        else if (wallish && f <= shadow_thr.clear_threshold &&
                 rt <= shadow_thr.clear_threshold && l <= shadow_thr.clear_threshold)
            nx = M_SPIN;
        else if (cur_mode == M_ADJR && rt > shadow_thr.far_threshold) nx = M_START;
        else if (cur_mode == M_ADJL && l > shadow_thr.far_threshold) nx = M_START;
        else if (cur_mode == M_SPIN && f > shadow_thr.clear_threshold &&
                 l <= shadow_thr.near_threshold) nx = M_ADJL;
        else if (cur_mode == M_SPIN && f > shadow_thr.clear_threshold &&
                 rt <= shadow_thr.near_threshold) nx = M_ADJR;

        cur_mode   = nx;
        r.mode_out = nx;
        modes_seen[nx] = 1'b1;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // mostly short idles, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // distances cluster around the live thresholds so the mode walk goes deep,
    // with some full range and saturated values for the bits
    function automatic logic [DIST_W-1:0] pick_dist();
        logic [DIST_W-1:0] base;
        int                v;
        case ($urandom_range(0, 9))
            0: return DIST_W'($urandom_range(0, 1023));
            1: return $urandom_range(0, 1) ? 10'd0 : 10'd1023;
            2: base = shadow_thr.near_threshold;
            3: base = shadow_thr.clear_threshold;
            4: base = shadow_thr.far_threshold;
            5: base = shadow_thr.band_low;
            6: base = shadow_thr.band_high;
            default: return DIST_W'($urandom_range(0, 80));
        endcase
        v = int'(base) + int'($urandom_range(0, 4)) - 2;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return v[DIST_W-1:0];
    endfunction

    // one sample request; valid stays high afterwards so back to back requests
    // need no extra assignment, the caller or the next gap lowers it
    task automatic send_sample(input logic [DIST_W-1:0] f, input logic [DIST_W-1:0] l,
                               input logic [DIST_W-1:0] r);
        int unsigned gap;
        t_in         s;
        s.front_dist = f;
        s.left_dist  = l;
        s.right_dist = r;
        gap = (!no_idle && $urandom_range(0, 99) < 30) ? idle_len() : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= s;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(advance_mode(s));
        samples_sent++;
    endtask

    task automatic send_random(input int unsigned count);
        repeat (count) send_sample(pick_dist(), pick_dist(), pick_dist());
    endtask

    // sender holds off until every predicted result has come back
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIST_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            R_FAR:   shadow_thr.far_threshold   = val;
            R_NEAR:  shadow_thr.near_threshold  = val;
            R_CLEAR: shadow_thr.clear_threshold = val;
            R_BLOW:  shadow_thr.band_low        = val;
            R_BHIGH: shadow_thr.band_high       = val;
            default: ;
        endcase
    endtask

    // registers change only with the pipeline empty
    task automatic apply_settings(input t_cfg c);
        settle();
        write_reg(R_FAR,   c.far_threshold);
        write_reg(R_NEAR,  c.near_threshold);
        write_reg(R_CLEAR, c.clear_threshold);
        write_reg(R_BLOW,  c.band_low);
        write_reg(R_BHIGH, c.band_high);
        i_cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // start mode commands under the reset thresholds, ending in a left wall
    task automatic test_start_mode();
        send_sample(100, 200, 300);     // front smallest and open: fast
        send_sample(40, 200, 300);      // front between near and far: slow
        send_sample(60, 200, 300);      // front exactly at far: hold
        send_sample(1023, 1023, 1023);  // three way tie: fast
        send_sample(300, 200, 100);     // right smallest: spin right
        send_sample(300, 100, 200);     // left smallest: spin left
        send_sample(0, 1023, 1023);     // front blocked: spin right
        send_sample(500, 20, 500);      // left at near: into adjust left
    endtask

    // walk through adjust, free and spin modes and back to start
    task automatic test_follow_modes();
        send_sample(100, 16, 900);      // left inside band: slow
        send_sample(100, 10, 900);      // below band: steer away
        send_sample(100, 19, 900);      // above band: steer toward
        send_sample(20, 16, 900);       // front blocked: turn right
        send_sample(100, 30, 900);      // both clear: free left
        send_sample(100, 5, 900);       // wall back on the left: adjust left
        send_sample(10, 100, 0);        // left opens past far: back to start
        send_sample(500, 300, 15);      // right at near: adjust right
        send_sample(100, 900, 17);      // right inside band: slow
        send_sample(100, 900, 5);       // below band: steer away
        send_sample(100, 900, 1023);    // both clear: free right
        send_sample(1023, 1023, 10);    // wall back on the right: adjust right
        send_sample(5, 5, 5);           // boxed in: spin
        send_sample(25, 10, 10);        // front not clear yet: stay in spin
        send_sample(26, 20, 900);       // spin out onto the left wall
        send_sample(5, 25, 25);         // boxed in from adjust left: spin
        send_sample(26, 900, 20);       // spin out onto the right wall
        send_sample(10, 900, 1023);     // right opens past far: back to start
    endtask

    // degenerate threshold settings: all zero, all saturated, near above far,
    // inverted band, full band
    task automatic test_register_extremes();
        apply_settings('{10'd0, 10'd0, 10'd0, 10'd0, 10'd0});
        send_random(25);
        apply_settings('{10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023});
        send_random(25);
        apply_settings('{10'd30, 10'd40, 10'd25, 10'd15, 10'd18});
        send_random(25);
        apply_settings('{10'd60, 10'd20, 10'd25, 10'd40, 10'd10});
        send_random(25);
        apply_settings('{10'd60, 10'd20, 10'd25, 10'd0, 10'd1023});
        send_random(20);
    endtask

    // random phases, each under its own thresholds, some without any idling
    task automatic test_random_traffic();
        t_cfg c;
        repeat (10) begin
            case ($urandom_range(0, 3))
                0: c = '{FAR_RST, NEAR_RST, CLEAR_RST, BLOW_RST, BHIGH_RST};
                1: begin
                    c.far_threshold   = DIST_W'($urandom_range(0, 1023));
                    c.near_threshold  = DIST_W'($urandom_range(0, 1023));
                    c.clear_threshold = DIST_W'($urandom_range(0, 1023));
                    c.band_low        = DIST_W'($urandom_range(0, 1023));
                    c.band_high       = DIST_W'($urandom_range(0, 1023));
                end
                default: begin
                    c.near_threshold  = DIST_W'($urandom_range(5, 40));
                    c.clear_threshold = c.near_threshold + DIST_W'($urandom_range(0, 15));
                    c.far_threshold   = c.clear_threshold + DIST_W'($urandom_range(0, 60));
                    c.band_low        = DIST_W'($urandom_range(0, 30));
                    c.band_high       = c.band_low + DIST_W'($urandom_range(0, 10));
                end
            endcase
            apply_settings(c);
            no_idle = ($urandom_range(0, 3) == 0);
            repeat (63) begin
                send_random(1);
                if ($urandom_range(0, 39) == 0) settle();
            end
            no_idle = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // result side: random backpressure and in-order checking
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result cmd=%0d led=%0d mode=%0d", $time,
                         o_out_data.drive_cmd, o_out_data.led_on, o_out_data.mode_out);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (o_out_data !== want) begin
                    $display("%0t: expected cmd=%0d led=%0d mode=%0d, got cmd=%0d led=%0d mode=%0d",
                             $time, want.drive_cmd, want.led_on, want.mode_out,
                             o_out_data.drive_cmd, o_out_data.led_on, o_out_data.mode_out);
                    mismatches++;
                end
            end
        end
        if (stall_left != 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else begin
            i_out_ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 99) < 15) stall_left <= idle_len();
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still outstanding", $time,
                     pending_results.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        shadow_thr = '{FAR_RST, NEAR_RST, CLEAR_RST, BLOW_RST, BHIGH_RST};
        cur_mode   = M_START;
        modes_seen = 6'b000001;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_start_mode();
        test_follow_modes();
        test_register_extremes();
        test_random_traffic();

        // drain, then leave room for any stray result
        settle();
        repeat (10) @(posedge i_clk);

        $display("covered %0d samples under %0d threshold settings, %0d results checked",
                 samples_sent, settings_applied, results_checked);
        $display("modes reached (spin..start): %b, mismatches: %0d", modes_seen, mismatches);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
